### hw/rtl/tcpc_pkg.sv
// tcpc_pkg: shared types, palettes and colour lookup for text_cell_pixel_colour
// used by tcpc_resolve, tcpc_blend and the top level; no dependencies
`timescale 1ns / 1ps

package tcpc_pkg;

    localparam int ChanW   = 8;
    localparam int IndexW  = 4;
    localparam int CoordW  = 8;
    localparam int AlphaW  = 8;
    localparam int PalSize = 8;
    localparam int PalIdxW = $clog2(PalSize);

    typedef struct packed {
        logic [ChanW-1:0] r;
        logic [ChanW-1:0] g;
        logic [ChanW-1:0] b;
    } rgb_t;

    // resolved colours of one pixel, after the inverse and cursor swaps
    typedef struct packed {
        rgb_t fg;
        rgb_t bg;
    } colour_pair_t;

    localparam rgb_t PalNormal [PalSize] = '{
        24'h000000, 24'hcc0000, 24'h4e9a06, 24'hc4a000,
        24'h3465a4, 24'h75507b, 24'h06989a, 24'hd3d7cf
    };

    localparam rgb_t PalBright [PalSize] = '{
        24'h555753, 24'hef2929, 24'h8ae234, 24'hfce94f,
        24'h729fcf, 24'had7fa8, 24'h34e2e2, 24'heeeeec
    };

    localparam logic [PalIdxW-1:0] DefFgSlot = PalIdxW'(7);
    localparam logic [PalIdxW-1:0] DefBgSlot = PalIdxW'(0);

    // index 8 and above is the default colour, always from the normal palette
    function automatic rgb_t pick_colour(
        input logic [IndexW-1:0] idx,
        input logic              bright,
        input logic [PalIdxW-1:0] dflt_slot
    );
        rgb_t colour;
        if (idx[IndexW-1])
            colour = PalNormal[dflt_slot];
        else if (bright)
            colour = PalBright[idx[PalIdxW-1:0]];
        else
            colour = PalNormal[idx[PalIdxW-1:0]];
        return colour;
    endfunction

endpackage

### hw/rtl/tcpc_resolve.sv
// tcpc_resolve: palette lookup and inverse / cursor swaps for one cell pixel
// depends on tcpc_pkg
`timescale 1ns / 1ps

module tcpc_resolve
    import tcpc_pkg::*;
(
    input  logic [IndexW-1:0] fg_index,
    input  logic [IndexW-1:0] bg_index,
    input  logic              bold,
    input  logic              inverse,
    input  logic              at_cursor,
    output colour_pair_t      colours
);

    rgb_t fg_pick;
    rgb_t bg_pick;
    logic swap;

    assign fg_pick = pick_colour(fg_index, bold, DefFgSlot);
    assign bg_pick = pick_colour(bg_index, bold, DefBgSlot);

    // two swaps cancel
    assign swap = inverse ^ at_cursor;

    always_comb
    begin
        if (swap)
        begin
            colours.fg = bg_pick;
            colours.bg = fg_pick;
        end
        else
        begin
            colours.fg = fg_pick;
            colours.bg = bg_pick;
        end
    end

endmodule

### hw/rtl/tcpc_blend.sv
// tcpc_blend: per-channel coverage blend of foreground over background
// depends on tcpc_pkg
`timescale 1ns / 1ps

module tcpc_blend
    import tcpc_pkg::*;
(
    input  colour_pair_t      colours,
    input  logic [AlphaW-1:0] glyph_alpha,
    output rgb_t              pixel
);

    localparam int WeightW = AlphaW + 1;
    localparam int SumW    = WeightW + ChanW;

    logic [WeightW-1:0] w_fg;
    logic [WeightW-1:0] w_bg;

    // weights always add up to 257
    assign w_fg = {1'b0, glyph_alpha} + WeightW'(1);
    assign w_bg = WeightW'(1 << AlphaW) - {1'b0, glyph_alpha};

    function automatic logic [ChanW-1:0] mix(
        input logic [ChanW-1:0]   f,
        input logic [ChanW-1:0]   b,
        input logic [WeightW-1:0] wf,
        input logic [WeightW-1:0] wb
    );
        logic [SumW-1:0] sum;
        sum = SumW'(wf) * SumW'(f) + SumW'(wb) * SumW'(b);
        return sum[AlphaW +: ChanW];
    endfunction

    assign pixel.r = mix(colours.fg.r, colours.bg.r, w_fg, w_bg);
    assign pixel.g = mix(colours.fg.g, colours.bg.g, w_fg, w_bg);
    assign pixel.b = mix(colours.fg.b, colours.bg.b, w_fg, w_bg);

endmodule

### hw/rtl/text_cell_pixel_colour.sv
// text_cell_pixel_colour: top level, colour of one glyph pixel of a text cell
// depends on tcpc_pkg, tcpc_resolve and tcpc_blend
`timescale 1ns / 1ps

// usage
//   input channel (item_valid / item_stall) carries one glyph pixel: cell and
//   cursor position, colour indices, bold, inverse and glyph coverage
//   output channel (pixel_valid / pixel_stall) carries the blended red, green
//   and blue of that pixel, one result item per input item, in order
//   an accepted item passes through the input register, then the result
//   register; palette lookup, swaps and blend sit between them
//   throughput: one item per cycle while pixel_stall stays low
//   when the receiver stalls, the result register holds its pixel; if the
//   input register is empty, one more item is still taken into it, after
//   which item_stall rises until the result register drains
//   reset (rst_n low, asynchronous) empties both stages; there is no other
//   state, so the block is ready for items as soon as reset is released
//   item_stall depends combinationally on pixel_stall; pixel_valid comes
//   straight from a register

module text_cell_pixel_colour
    import tcpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              item_valid,
    output logic              item_stall,
    input  logic [CoordW-1:0] cell_col,
    input  logic [CoordW-1:0] cell_row,
    input  logic [CoordW-1:0] cursor_col,
    input  logic [CoordW-1:0] cursor_row,
    input  logic [IndexW-1:0] fg_index,
    input  logic [IndexW-1:0] bg_index,
    input  logic              bold,
    input  logic              inverse,
    input  logic [AlphaW-1:0] glyph_alpha,

    output logic              pixel_valid,
    input  logic              pixel_stall,
    output logic [ChanW-1:0]  red,
    output logic [ChanW-1:0]  green,
    output logic [ChanW-1:0]  blue
);

    // input stage
    logic              in_valid_reg;
    logic              in_valid_next;
    logic              at_cursor_reg;
    logic [IndexW-1:0] fg_index_reg;
    logic [IndexW-1:0] bg_index_reg;
    logic              bold_reg;
    logic              inverse_reg;
    logic [AlphaW-1:0] alpha_reg;

    // result stage
    logic              out_valid_reg;
    logic              out_valid_next;
    rgb_t              pixel_reg;

    logic              out_ready;
    logic              in_ready;
    logic              item_take;
    logic              result_load;

    colour_pair_t      colours;
    rgb_t              pixel_mix;

    // result register frees when empty or when its pixel is taken
    assign out_ready   = !out_valid_reg || !pixel_stall;
    assign in_ready    = !in_valid_reg || out_ready;
    assign item_stall  = !in_ready;
    assign item_take   = item_valid && in_ready;
    assign result_load = in_valid_reg && out_ready;

    always_comb
    begin
        if (item_take)
            in_valid_next = 1'b1;
        else if (out_ready)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (out_ready)
            out_valid_next = in_valid_reg;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // cursor compare is done on the way in, so only one bit is held
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            at_cursor_reg <= (cell_col == cursor_col) && (cell_row == cursor_row);
            fg_index_reg  <= fg_index;
            bg_index_reg  <= bg_index;
            bold_reg      <= bold;
            inverse_reg   <= inverse;
            alpha_reg     <= glyph_alpha;
        end
    end

    tcpc_resolve u_resolve (
        .fg_index  (fg_index_reg),
        .bg_index  (bg_index_reg),
        .bold      (bold_reg),
        .inverse   (inverse_reg),
        .at_cursor (at_cursor_reg),
        .colours   (colours)
    );

    tcpc_blend u_blend (
        .colours     (colours),
        .glyph_alpha (alpha_reg),
        .pixel       (pixel_mix)
    );

    always_ff @(posedge clk)
    begin
        if (result_load)
            pixel_reg <= pixel_mix;
    end

    assign pixel_valid = out_valid_reg;
    assign red         = pixel_reg.r;
    assign green       = pixel_reg.g;
    assign blue        = pixel_reg.b;

    // stall toward the sender only when both stages are full and blocked
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (in_valid_reg && out_valid_reg && pixel_stall))
        else $error("item_stall raised with room in the pipeline");

    // a held input item is not dropped while the result stage is blocked
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_ready) |=> in_valid_reg)
        else $error("input item lost while result stage blocked");

    // an input item moving forward shows up as a result next cycle
    a_forward: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> pixel_valid)
        else $error("forwarded item missing from result stage");

    // a stalled result keeps its pixel
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel_stall) |=> $stable(pixel_reg))
        else $error("result register changed under stall");

endmodule
